/* rtl/ism_pkg.sv */
// shared widths, register indexes, reset values and sequencer steps for the spin update block
package ism_pkg;

    localparam int SIDE_DEFAULT = 16;

    localparam int COORD_W   = 4;
    localparam int Q_W       = 16;
    localparam int THR_W     = 24;
    localparam int DE_W      = 21;
    localparam int MAG_W     = 14;
    localparam int ACC_W     = 20;
    localparam int STEP_W    = 4;
    localparam int CFG_IDX_W = 2;

    typedef logic signed [Q_W-1:0] q88_t;
    typedef logic signed [ACC_W-1:0] acc_t;
    typedef logic signed [DE_W-1:0] energy_t;
    typedef logic signed [MAG_W-1:0] mag_t;

    localparam logic [CFG_IDX_W-1:0] CFG_NEAR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIAG  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIELD = 2'd2;

    localparam q88_t NEAR_RST  = 16'sd256;
    localparam q88_t DIAG_RST  = 16'sd128;
    localparam q88_t FIELD_RST = 16'sd256;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_TRIAL = 1'b1;

    localparam logic [STEP_W-1:0] STEP_CENTRE    = 4'd0;
    localparam logic [STEP_W-1:0] STEP_LAST_NEAR = 4'd6;
    localparam logic [STEP_W-1:0] STEP_LAST      = 4'd14;
    localparam logic [STEP_W-1:0] STEP_DONE      = 4'd15;

endpackage

/* rtl/ism_ram.sv */
// generic single write port, single read port ram with registered read data
module ism_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/ising_metropolis_spin_update.sv */
// top level: metropolis spin update over a periodic cubic lattice held in one ram
//
//  channel   direction  handshake             payload
//  in        to block   in_valid / in_stall   req_type site_x site_y site_z spin_value
//                                             accept_threshold
//  out       from block out_valid / out_stall accepted spin_now energy_change magnetization
//  cfg       to block   cfg_valid / cfg_ready cfg_index cfg_data
//
//  between beats a trial makes fifteen lattice reads through the single read port of the
//  lattice ram, takes the last read data, evaluates and returns to idle; a load reads only
//  the centre site before it evaluates and returns to idle
//  after reset a clearing pass writes +1 to all LATTICE_SIDE^3 sites
//  with in_stall high; configuration writes are taken throughout
//  the result register frees the input side; evaluation waits while a result is still stalled
module ising_metropolis_spin_update #(
    parameter int LATTICE_SIDE = ism_pkg::SIDE_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              req_type,
    input  logic [ism_pkg::COORD_W-1:0]       site_x,
    input  logic [ism_pkg::COORD_W-1:0]       site_y,
    input  logic [ism_pkg::COORD_W-1:0]       site_z,
    input  logic                              spin_value,
    input  logic [ism_pkg::THR_W-1:0]         accept_threshold,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              accepted,
    output logic                              spin_now,
    output logic signed [ism_pkg::DE_W-1:0]   energy_change,
    output logic signed [ism_pkg::MAG_W-1:0]  magnetization,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ism_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ism_pkg::Q_W-1:0]           cfg_data
);

    import ism_pkg::*;

    localparam int SITES      = LATTICE_SIDE * LATTICE_SIDE * LATTICE_SIDE;
    localparam int AW         = $clog2(SITES);
    localparam int CW         = $clog2(LATTICE_SIDE);
    localparam int COORD_SPAN = 2 ** COORD_W;
    localparam logic [AW-1:0] LAST_SITE = AW'(SITES - 1);
    localparam logic [CW-1:0] LAST_COORD = CW'(LATTICE_SIDE - 1);
    localparam logic [AW-1:0] PLANE = AW'(LATTICE_SIDE * LATTICE_SIDE);
    localparam logic [AW-1:0] ROW = AW'(LATTICE_SIDE);
    localparam mag_t MAG_INIT = MAG_W'(SITES);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_READ  = 2'd2;
    localparam logic [1:0] ST_EVAL  = 2'd3;

    function automatic logic [AW-1:0] site_addr(
        input logic [CW-1:0] ax,
        input logic [CW-1:0] ay,
        input logic [CW-1:0] az
    );
        site_addr = AW'(ax) * PLANE + AW'(ay) * ROW + AW'(az);
    endfunction

    function automatic logic [CW-1:0] wrap_dec(input logic [CW-1:0] c);
        wrap_dec = (c == '0) ? LAST_COORD : c - CW'(1);
    endfunction

    function automatic logic [CW-1:0] wrap_inc(input logic [CW-1:0] c);
        wrap_inc = (c == LAST_COORD) ? '0 : c + CW'(1);
    endfunction

    logic [1:0]        state_reg, state_next;
    logic [AW-1:0]     clr_reg, clr_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              trial_reg;
    logic [CW-1:0]     x_reg, y_reg, z_reg;
    logic              spin_in_reg;
    logic [THR_W-1:0]  thr_reg;
    logic              centre_reg;
    acc_t              acc_reg, acc_next;
    mag_t              mag_reg, mag_next;
    q88_t              near_reg, diag_reg, field_reg;

    logic              out_valid_reg;
    logic              accepted_reg;
    logic              spin_now_reg;
    energy_t           energy_reg;

    logic [CW-1:0]     mod_tab [COORD_SPAN];
    logic [CW-1:0]     xm, xp, ym, yp, zm, zp;
    logic [AW-1:0]     rd_addr;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [0:0]        ram_wdata;
    logic [0:0]        ram_rdata;

    logic [STEP_W-1:0] data_idx;
    acc_t              term;
    energy_t           de;
    logic signed [THR_W:0] de_wide, thr_wide;
    logic              flip;
    logic              new_spin;
    logic              changed;
    logic              out_free;
    logic              take_in;
    logic              finish;

    for (genvar i = 0; i < COORD_SPAN; i++)
    begin : g_mod
        assign mod_tab[i] = CW'(i % LATTICE_SIDE);
    end

    assign xm = wrap_dec(x_reg);
    assign xp = wrap_inc(x_reg);
    assign ym = wrap_dec(y_reg);
    assign yp = wrap_inc(y_reg);
    assign zm = wrap_dec(z_reg);
    assign zp = wrap_inc(z_reg);

    always_comb
    begin
        case (cnt_reg)
            4'd1:    rd_addr = site_addr(xm, y_reg, z_reg);
            4'd2:    rd_addr = site_addr(xp, y_reg, z_reg);
            4'd3:    rd_addr = site_addr(x_reg, ym, z_reg);
            4'd4:    rd_addr = site_addr(x_reg, yp, z_reg);
            4'd5:    rd_addr = site_addr(x_reg, y_reg, zm);
            4'd6:    rd_addr = site_addr(x_reg, y_reg, zp);
            4'd7:    rd_addr = site_addr(xm, y_reg, zm);
            4'd8:    rd_addr = site_addr(x_reg, ym, zm);
            4'd9:    rd_addr = site_addr(xp, y_reg, zm);
            4'd10:   rd_addr = site_addr(x_reg, yp, zm);
            4'd11:   rd_addr = site_addr(xm, y_reg, zp);
            4'd12:   rd_addr = site_addr(x_reg, ym, zp);
            4'd13:   rd_addr = site_addr(xp, y_reg, zp);
            4'd14:   rd_addr = site_addr(x_reg, yp, zp);
            default: rd_addr = site_addr(x_reg, y_reg, z_reg);
        endcase
    end

    ism_ram #(
        .WIDTH (1),
        .DEPTH (SITES)
    ) u_lattice (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // neighbour accumulation, data of step cnt-1 arrives at step cnt
    assign data_idx = cnt_reg - STEP_W'(1);
    assign term = (data_idx <= STEP_LAST_NEAR) ? ACC_W'(near_reg) : ACC_W'(diag_reg);

    always_comb
    begin
        acc_next = acc_reg;
        if (take_in)
        begin
            acc_next = ACC_W'(field_reg);
        end
        else if (state_reg == ST_READ && cnt_reg > STEP_CENTRE + STEP_W'(1))
        begin
            acc_next = ram_rdata[0] ? acc_reg + term : acc_reg - term;
        end
    end

    // energy change and decision
    assign de       = centre_reg ? {acc_reg, 1'b0} : -{acc_reg, 1'b0};
    assign de_wide  = {{(THR_W + 1 - DE_W){de[DE_W-1]}}, de};
    assign thr_wide = {1'b0, thr_reg};
    assign flip     = trial_reg && (de_wide < thr_wide);
    assign new_spin = trial_reg ? (centre_reg ^ flip) : spin_in_reg;
    assign changed  = new_spin != centre_reg;

    assign out_free = !out_valid_reg || !out_stall;
    assign take_in  = in_valid && !in_stall;
    assign finish   = (state_reg == ST_EVAL) && out_free;

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = site_addr(x_reg, y_reg, z_reg);
        ram_wdata = new_spin;
        if (state_reg == ST_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_reg;
            ram_wdata = 1'b1;
        end
        else if (finish && changed)
        begin
            ram_we = 1'b1;
        end
    end

    always_comb
    begin
        mag_next = mag_reg;
        if (finish && changed)
        begin
            mag_next = new_spin ? mag_reg + MAG_W'(2) : mag_reg - MAG_W'(2);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + AW'(1);
                if (clr_reg == LAST_SITE)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                cnt_next = STEP_CENTRE;
                if (take_in)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                cnt_next = cnt_reg + STEP_W'(1);
                if (cnt_reg == STEP_DONE
                    || (!trial_reg && cnt_reg == STEP_CENTRE + STEP_W'(1)))
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            cnt_reg       <= STEP_CENTRE;
            mag_reg       <= MAG_INIT;
            near_reg      <= NEAR_RST;
            diag_reg      <= DIAG_RST;
            field_reg     <= FIELD_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            cnt_reg   <= cnt_next;
            mag_reg   <= mag_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_NEAR:  near_reg  <= cfg_data;
                    CFG_DIAG:  diag_reg  <= cfg_data;
                    CFG_FIELD: field_reg <= cfg_data;
                    default:   ;
                endcase
            end
            if (finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (take_in)
        begin
            trial_reg   <= req_type;
            x_reg       <= mod_tab[site_x];
            y_reg       <= mod_tab[site_y];
            z_reg       <= mod_tab[site_z];
            spin_in_reg <= spin_value;
            thr_reg     <= accept_threshold;
        end
        if (state_reg == ST_READ && cnt_reg == STEP_CENTRE + STEP_W'(1))
        begin
            centre_reg <= ram_rdata[0];
        end
        if (finish)
        begin
            accepted_reg <= flip;
            spin_now_reg <= new_spin;
            energy_reg   <= flip ? de : '0;
        end
    end

    assign in_stall      = state_reg != ST_IDLE;
    assign cfg_ready     = 1'b1;
    assign out_valid     = out_valid_reg;
    assign accepted      = accepted_reg;
    assign spin_now      = spin_now_reg;
    assign energy_change = energy_reg;
    assign magnetization = mag_reg;

    // a spin write at the end of an item always moves the magnetization
    a_mag_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EVAL && ram_we) |=> (mag_reg != $past(mag_reg)))
        else $error("magnetization unchanged after spin write");

    // a load never reports a flip
    a_load_not_accepted: assert property (@(posedge clk) disable iff (!rst_n)
        (finish && trial_reg == REQ_LOAD) |=> !accepted)
        else $error("load reported as accepted");

    // evaluation only follows the read sequence
    a_eval_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EVAL) |->
            ($past(state_reg) == ST_READ || $past(state_reg) == ST_EVAL))
        else $error("evaluation entered without lattice reads");

    // the neighbour accumulation steps are reached only by a trial
    a_trial_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ && cnt_reg > STEP_CENTRE + STEP_W'(1)) |-> trial_reg)
        else $error("neighbour reads issued for a load");

endmodule

/* dv/testbench.sv */
// self-checking testbench for the metropolis spin update block with its own lattice predictor
`timescale 1ns / 100ps

module testbench;

    import ism_pkg::*;

    localparam int   CYCLE_LIMIT     = 600000;
    localparam int   HOLD_OFF_CYCLES = 500;
    localparam int   SITES           = SIDE_DEFAULT * SIDE_DEFAULT * SIDE_DEFAULT;
    localparam q88_t Q_MAX           = 16'sh7FFF;
    localparam q88_t Q_MIN           = 16'sh8000;

    typedef struct {
        logic                kind;
        logic [COORD_W-1:0]  x;
        logic [COORD_W-1:0]  y;
        logic [COORD_W-1:0]  z;
        logic                spin;
        logic [THR_W-1:0]    threshold;
    } spin_req_t;

    typedef struct {
        logic    flipped;
        logic    spin;
        energy_t energy;
        mag_t    mag;
    } spin_outcome_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic                 req_type;
    logic [COORD_W-1:0]   site_x;
    logic [COORD_W-1:0]   site_y;
    logic [COORD_W-1:0]   site_z;
    logic                 spin_value;
    logic [THR_W-1:0]     accept_threshold;
    logic                 out_valid;
    logic                 out_stall;
    logic                 accepted;
    logic                 spin_now;
    logic signed [DE_W-1:0]  energy_change;
    logic signed [MAG_W-1:0] magnetization;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [Q_W-1:0]       cfg_data;

    logic          lattice_model [0:SITES-1];
    mag_t          mag_model;
    q88_t          near_model;
    q88_t          diag_model;
    q88_t          field_model;
    spin_outcome_t pending_outcomes [$];

    int           mismatch_count;
    int           cycle_count;
    int           burst_left;
    int           gap_max;
    bit           hold_request;
    logic [COORD_W-1:0] cluster_x;
    logic [COORD_W-1:0] cluster_y;
    logic [COORD_W-1:0] cluster_z;

    ising_metropolis_spin_update uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .req_type         (req_type),
        .site_x           (site_x),
        .site_y           (site_y),
        .site_z           (site_z),
        .spin_value       (spin_value),
        .accept_threshold (accept_threshold),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .accepted         (accepted),
        .spin_now         (spin_now),
        .energy_change    (energy_change),
        .magnetization    (magnetization),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic int site_sign(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                     logic [COORD_W-1:0] z);
        return lattice_model[{x, y, z}] ? 1 : -1;
    endfunction

    function automatic void predict_outcome(spin_req_t r);
        logic [COORD_W-1:0] xm, xp, ym, yp, zm, zp;
        logic [3*COORD_W-1:0] site;
        int sum_near;
        int sum_diag;
        int local_field;
        int de;
        int thr;
        spin_outcome_t o;
        site = {r.x, r.y, r.z};
        o.flipped = 1'b0;
        o.energy = '0;
        if (r.kind == REQ_LOAD)
        begin
            if (lattice_model[site] != r.spin)
            begin
                lattice_model[site] = r.spin;
                mag_model = mag_model + (r.spin ? 14'sd2 : -14'sd2);
            end
        end
        else
        begin
            // side is a power of two, so 4-bit arithmetic gives the periodic wrap
            xm = r.x - 1'b1;
            xp = r.x + 1'b1;
            ym = r.y - 1'b1;
            yp = r.y + 1'b1;
            zm = r.z - 1'b1;
            zp = r.z + 1'b1;
            sum_near = site_sign(xm, r.y, r.z) + site_sign(xp, r.y, r.z)
                     + site_sign(r.x, ym, r.z) + site_sign(r.x, yp, r.z)
                     + site_sign(r.x, r.y, zm) + site_sign(r.x, r.y, zp);
            sum_diag = site_sign(xm, r.y, zm) + site_sign(r.x, ym, zm)
                     + site_sign(xp, r.y, zm) + site_sign(r.x, yp, zm)
                     + site_sign(xm, r.y, zp) + site_sign(r.x, ym, zp)
                     + site_sign(xp, r.y, zp) + site_sign(r.x, yp, zp);
            local_field = near_model * sum_near + diag_model * sum_diag + field_model;
            de = 2 * site_sign(r.x, r.y, r.z) * local_field;
            thr = r.threshold;
            if (de < 0 || de < thr)
            begin
                lattice_model[site] = ~lattice_model[site];
                mag_model = mag_model + (lattice_model[site] ? 14'sd2 : -14'sd2);
                o.flipped = 1'b1;
                o.energy = energy_t'(de);
            end
        end
        o.spin = lattice_model[site];
        o.mag = mag_model;
        pending_outcomes.push_back(o);
    endfunction

    function automatic spin_req_t make_req(logic kind, int x, int y, int z, logic spin,
                                           logic [THR_W-1:0] threshold);
        spin_req_t r;
        r.kind = kind;
        r.x = COORD_W'(x);
        r.y = COORD_W'(y);
        r.z = COORD_W'(z);
        r.spin = spin;
        r.threshold = threshold;
        return r;
    endfunction

    function automatic spin_req_t random_req(logic kind);
        spin_req_t r;
        r.kind = kind;
        if ($urandom_range(0, 3) != 0)
        begin
            r.x = cluster_x + COORD_W'($urandom_range(0, 3));
            r.y = cluster_y + COORD_W'($urandom_range(0, 3));
            r.z = cluster_z + COORD_W'($urandom_range(0, 3));
        end
        else
        begin
            r.x = COORD_W'($urandom);
            r.y = COORD_W'($urandom);
            r.z = COORD_W'($urandom);
        end
        r.spin = 1'($urandom);
        case ($urandom_range(0, 4))
            0: r.threshold = '0;
            1: r.threshold = THR_W'($urandom_range(0, 4095));
            2: r.threshold = THR_W'($urandom_range(0, 65535));
            3: r.threshold = THR_W'($urandom_range(0, 1 << 20));
            default: r.threshold = THR_W'($urandom);
        endcase
        return r;
    endfunction

    function automatic q88_t pick_coupling();
        case ($urandom_range(0, 5))
            0: return Q_MIN;
            1: return Q_MAX;
            2: return '0;
            3: return q88_t'($urandom_range(0, 65535));
            default: return q88_t'(int'($urandom_range(0, 1024)) - 512);
        endcase
    endfunction

    task automatic send_item(spin_req_t r);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, gap_max);
            burst_left = $urandom_range(1, 40);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid         <= 1'b1;
        req_type         <= r.kind;
        site_x           <= r.x;
        site_y           <= r.y;
        site_z           <= r.z;
        spin_value       <= r.spin;
        accept_threshold <= r.threshold;
        do @(posedge clk); while (in_stall);
        predict_outcome(r);
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (pending_outcomes.size() != 0);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, q88_t value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_NEAR:  near_model = value;
            CFG_DIAG:  diag_model = value;
            CFG_FIELD: field_model = value;
            default: ;
        endcase
    endtask

    task automatic set_couplings(q88_t near, q88_t diag, q88_t field);
        write_register(CFG_NEAR, near);
        write_register(CFG_DIAG, diag);
        write_register(CFG_FIELD, field);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(q88_t near, q88_t diag, q88_t field, int load_count,
                             int item_count);
        wait_for_results();
        set_couplings(near, diag, field);
        cluster_x = COORD_W'($urandom);
        cluster_y = COORD_W'($urandom);
        cluster_z = COORD_W'($urandom);
        // scramble the cluster first so the neighbour sums vary
        repeat (load_count) send_item(random_req(REQ_LOAD));
        repeat (item_count)
            send_item(random_req(($urandom_range(0, 9) < 7) ? REQ_TRIAL : REQ_LOAD));
    endtask

    task automatic test_load_and_trial_corners();
        // reset couplings on an all-up lattice give a trial energy of 5632
        send_item(make_req(REQ_TRIAL, 5, 5, 5, 1'b0, 24'd0));
        send_item(make_req(REQ_TRIAL, 5, 5, 5, 1'b1, 24'd5632));
        send_item(make_req(REQ_TRIAL, 5, 5, 5, 1'b0, 24'd5633));
        send_item(make_req(REQ_TRIAL, 5, 5, 5, 1'b1, 24'd0));
        send_item(make_req(REQ_TRIAL, 9, 9, 9, 1'b0, 24'hFFFFFF));
        send_item(make_req(REQ_LOAD, 0, 0, 0, 1'b0, 24'hFFFFFF));
        send_item(make_req(REQ_LOAD, 0, 0, 0, 1'b0, 24'h000000));
        send_item(make_req(REQ_LOAD, 15, 15, 15, 1'b0, 24'h555555));
        send_item(make_req(REQ_LOAD, 15, 0, 15, 1'b0, 24'hAAAAAA));
        send_item(make_req(REQ_LOAD, 0, 15, 0, 1'b0, 24'h0));
        send_item(make_req(REQ_TRIAL, 0, 0, 0, 1'b1, 24'd0));
        send_item(make_req(REQ_TRIAL, 15, 15, 15, 1'b0, 24'h800000));
        send_item(make_req(REQ_TRIAL, 0, 15, 0, 1'b1, 24'h00FFFF));
        send_item(make_req(REQ_TRIAL, 15, 0, 15, 1'b0, 24'd1));
        send_item(make_req(REQ_LOAD, 0, 0, 0, 1'b1, 24'd0));
        send_item(make_req(REQ_LOAD, 15, 15, 15, 1'b1, 24'hFFFFFF));
        send_item(make_req(REQ_LOAD, 10, 5, 3, 1'b1, 24'hFFFFFF));
        send_item(make_req(REQ_TRIAL, 3, 10, 12, 1'b1, 24'hAAAAAA));
        send_item(make_req(REQ_TRIAL, 12, 3, 10, 1'b0, 24'h555555));
        send_item(make_req(REQ_TRIAL, 0, 0, 15, 1'b1, 24'd0));
    endtask

    task automatic test_coupling_extremes();
        run_phase(Q_MAX, Q_MAX, Q_MAX, 5, 20);
        run_phase(Q_MIN, Q_MIN, Q_MIN, 5, 20);
        run_phase('0, '0, '0, 5, 20);
        run_phase(Q_MIN, Q_MAX, '0, 5, 20);
        run_phase(Q_MAX, Q_MIN, Q_MIN, 5, 20);
    endtask

    task automatic test_output_backpressure();
        wait_for_results();
        gap_max = 0;
        hold_request = 1'b1;
        repeat (24) send_item(random_req(($urandom_range(0, 1) != 0) ? REQ_TRIAL : REQ_LOAD));
        gap_max = 20;
        wait_for_results();
    endtask

    task automatic test_random_sweeps();
        repeat (6) run_phase(pick_coupling(), pick_coupling(), pick_coupling(), 12, 138);
    endtask

    // receiver stall pattern, with a long hold-off on request
    initial
    begin
        int mode;
        int stretch;
        out_stall = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            else
            begin
                mode = $urandom_range(0, 3);
                stretch = $urandom_range(4, 64);
                for (int k = 0; k < stretch && !hold_request; k++)
                begin
                    case (mode)
                        0: out_stall <= 1'b0;
                        1: out_stall <= ($urandom_range(0, 3) == 0);
                        2: out_stall <= ($urandom_range(0, 3) != 0);
                        default: out_stall <= k[0];
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        spin_outcome_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_outcomes.size() == 0)
            begin
                mismatch_count++;
                $display("%0t result beat with nothing expected: accepted %0d spin %0d de %0d mag %0d",
                         $time, accepted, spin_now, energy_change, magnetization);
            end
            else
            begin
                want = pending_outcomes.pop_front();
                if (accepted !== want.flipped)
                begin
                    mismatch_count++;
                    $display("%0t accepted: expected %0d actual %0d",
                             $time, want.flipped, accepted);
                end
                if (spin_now !== want.spin)
                begin
                    mismatch_count++;
                    $display("%0t spin_now: expected %0d actual %0d", $time, want.spin, spin_now);
                end
                if (energy_change !== want.energy)
                begin
                    mismatch_count++;
                    $display("%0t energy_change: expected %0d actual %0d",
                             $time, want.energy, energy_change);
                end
                if (magnetization !== want.mag)
                begin
                    mismatch_count++;
                    $display("%0t magnetization: expected %0d actual %0d",
                             $time, want.mag, magnetization);
                end
            end
        end
    end

    initial
    begin
        rst_n            = 1'b0;
        in_valid         = 1'b0;
        req_type         = REQ_LOAD;
        site_x           = '0;
        site_y           = '0;
        site_z           = '0;
        spin_value       = 1'b0;
        accept_threshold = '0;
        cfg_valid        = 1'b0;
        cfg_index        = CFG_NEAR;
        cfg_data         = '0;
        mismatch_count   = 0;
        cycle_count      = 0;
        burst_left       = 0;
        gap_max          = 20;
        hold_request     = 1'b0;
        cluster_x        = '0;
        cluster_y        = '0;
        cluster_z        = '0;
        for (int i = 0; i < SITES; i++)
            lattice_model[i] = 1'b1;
        mag_model   = mag_t'(SITES);
        near_model  = NEAR_RST;
        diag_model  = DIAG_RST;
        field_model = FIELD_RST;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_load_and_trial_corners();
        test_coupling_extremes();
        test_output_backpressure();
        test_random_sweeps();

        wait_for_results();
        repeat (40) @(posedge clk);
        if (mismatch_count == 0 && pending_outcomes.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
